### rtl/akf_pkg.sv
package akf_pkg;

	// fraction bits of the internal format
	localparam int FRAC = 40;
	// dividend bits that can be nonzero: magnitude shifted up by the fraction
	localparam int DIV_BITS = 64 + FRAC;
	localparam int CNT_W = $clog2(DIV_BITS + 1);

	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_TIME_STEP = 3'd0,
		CFG_MEAS_VAR  = 3'd1,
		CFG_RES_THR   = 3'd2,
		CFG_INIT_PVAR = 3'd3,
		CFG_LOW_PVAR  = 3'd4,
		CFG_HIGH_PVAR = 3'd5,
		CFG_INIT_COV  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] y;
	} alu_rsp_t;

	// magnitude of a signed 64-bit value
	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	// signed value from magnitude and sign, clamped to the signed range
	function automatic logic [63:0] sat_from(input logic [63:0] m, input logic neg);
		logic [63:0] lim;
		logic [63:0] mc;
		lim = neg ? MIN64 : MAX64;
		mc  = (m > lim) ? lim : m;
		sat_from = neg ? (64'd0 - mc) : mc;
	endfunction

endpackage

### rtl/akf_sample_if.sv
interface akf_sample_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] sample;
	logic        start_of_series;

	modport source(output valid, output sample, output start_of_series, input ready);
	modport sink(input valid, input sample, input start_of_series, output ready);
endinterface

### rtl/akf_result_if.sv
interface akf_result_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] filtered_position;
	logic [62:0] normalized_residual;

	modport source(output valid, output filtered_position, output normalized_residual,
		input ready);
	modport sink(input valid, input filtered_position, input normalized_residual,
		output ready);
endinterface

### rtl/adaptive_kalman_2state_core.sv
// Two-state constant-velocity Kalman filter with adaptive process noise.
// samples: sink channel; one transfer carries one sample (signed Q16.16)
//   and a start_of_series flag that reloads the state from that sample.
// results: source channel; exactly one transfer per sample, carrying the
//   filtered position (Q16.16, saturated) and the normalized residual.
// cfg_we/cfg_index/cfg_data: register writes, taken at any edge with
//   cfg_we high; write only while the filter is idle. Unknown index ignored.
// Datapath: all arithmetic runs through one shared unit under a small
//   program of 33 steps: 16 multiplies (four 32x32 partial products plus
//   rounding), 14 adds and 3 divides (one quotient bit per cycle). A new
//   sample is taken only once the previous result has entered the output
//   register.
// Reset: registers return to their defaults, state and covariance to zero,
//   noise level to initial; no result is pending.
// Stall: a result waits in the output register while results.ready is low;
//   the filter finishes its next sample and then holds until the slot frees.
module adaptive_kalman_2state_core (
	input  logic        clk,
	input  logic        arst_n,
	akf_sample_if.sink  samples,
	akf_result_if.source results,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [62:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_WB   = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		NL_INIT = 2'd0,
		NL_LOW  = 2'd1,
		NL_HIGH = 2'd2
	} noise_t;

	typedef enum logic [4:0] {
		D_DT2, D_DT3, D_DT4, D_Q00, D_Q01, D_Q11, D_TMP, D_XP, D_A, D_B,
		D_P00, D_P01, D_P11, D_S, D_K0, D_K1, D_Y, D_RES, D_POS, D_VEL,
		D_C00, D_C01, D_C11
	} dst_t;

	localparam logic [5:0] LAST_STEP = 6'd32;

	// configuration registers
	logic [31:0] time_step_q;
	logic [62:0] meas_var_q, res_thr_q, init_pvar_q, low_pvar_q, high_pvar_q, init_cov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 32'd838861;
			meas_var_q  <= 63'd4398046511104;
			res_thr_q   <= 63'd43980465111;
			init_pvar_q <= 63'd27487791;
			low_pvar_q  <= 63'd274878;
			high_pvar_q <= 63'd275097853250020311;
			init_cov_q  <= 63'd109951162778;
		end else if (cfg_we) begin
			unique case (cfg_index)
				akf_pkg::CFG_TIME_STEP: time_step_q <= cfg_data[31:0];
				akf_pkg::CFG_MEAS_VAR:  meas_var_q  <= cfg_data;
				akf_pkg::CFG_RES_THR:   res_thr_q   <= cfg_data;
				akf_pkg::CFG_INIT_PVAR: init_pvar_q <= cfg_data;
				akf_pkg::CFG_LOW_PVAR:  low_pvar_q  <= cfg_data;
				akf_pkg::CFG_HIGH_PVAR: high_pvar_q <= cfg_data;
				akf_pkg::CFG_INIT_COV:  init_cov_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q;
	logic [5:0] step_q;
	logic       issued_q;
	noise_t     noise_q;

	// filter state and working registers
	logic [63:0] pos_q, vel_q, c00_q, c01_q, c11_q;
	logic [63:0] z_q, qv_q;
	logic [63:0] dt2_q, dt3_q, dt4_q, q00_q, q01_q, q11_q, tmp_q, xp_q, a_q, b_q;
	logic [63:0] p00_q, p01_q, p11_q, s_q, k0_q, k1_q, y_q, res_q;

	logic        out_vld_q;
	logic [31:0] out_pos_q;
	logic [62:0] out_res_q;

	logic [63:0] dt_w, z_w;
	assign dt_w = 64'(time_step_q) << (akf_pkg::FRAC - 24);
	assign z_w  = {{32{samples.sample[31]}}, samples.sample} << (akf_pkg::FRAC - 16);

	logic in_xfer;
	assign in_xfer = samples.valid && samples.ready;
	assign samples.ready = (state_q == S_IDLE);

	// step program: operation, operands, destination and post shift
	akf_pkg::alu_req_t req;
	akf_pkg::alu_rsp_t rsp;
	dst_t        dst;
	logic [1:0]  shr;

	always_comb begin
		req.start = (state_q == S_RUN) && !issued_q;
		req.op    = akf_pkg::OP_MUL;
		req.a     = dt_w;
		req.b     = dt_w;
		dst       = D_DT2;
		shr       = 2'd0;
		unique case (step_q)
			6'd0:  begin req.a = dt_w;  req.b = dt_w;  dst = D_DT2; end
			6'd1:  begin req.a = dt2_q; req.b = dt_w;  dst = D_DT3; end
			6'd2:  begin req.a = dt2_q; req.b = dt2_q; dst = D_DT4; end
			6'd3:  begin req.a = dt4_q; req.b = qv_q;  dst = D_Q00; shr = 2'd2; end
			6'd4:  begin req.a = dt3_q; req.b = qv_q;  dst = D_Q01; shr = 2'd1; end
			6'd5:  begin req.a = dt2_q; req.b = qv_q;  dst = D_Q11; end
			6'd6:  begin req.a = dt_w;  req.b = vel_q; dst = D_TMP; end
			6'd7:  begin req.op = akf_pkg::OP_ADD; req.a = pos_q; req.b = tmp_q; dst = D_XP; end
			6'd8:  begin req.a = dt_w;  req.b = c01_q; dst = D_TMP; end
			6'd9:  begin req.op = akf_pkg::OP_ADD; req.a = c00_q; req.b = tmp_q; dst = D_A; end
			6'd10: begin req.a = dt_w;  req.b = c11_q; dst = D_TMP; end
			6'd11: begin req.op = akf_pkg::OP_ADD; req.a = c01_q; req.b = tmp_q; dst = D_B; end
			6'd12: begin req.a = dt_w;  req.b = b_q;   dst = D_TMP; end
			6'd13: begin req.op = akf_pkg::OP_ADD; req.a = a_q; req.b = tmp_q; dst = D_TMP; end
			6'd14: begin req.op = akf_pkg::OP_ADD; req.a = tmp_q; req.b = q00_q; dst = D_P00; end
			6'd15: begin req.op = akf_pkg::OP_ADD; req.a = b_q; req.b = q01_q; dst = D_P01; end
			6'd16: begin req.op = akf_pkg::OP_ADD; req.a = c11_q; req.b = q11_q; dst = D_P11; end
			6'd17: begin
				req.op = akf_pkg::OP_ADD; req.a = p00_q; req.b = {1'b0, meas_var_q}; dst = D_S;
			end
			6'd18: begin req.op = akf_pkg::OP_DIV; req.a = p00_q; req.b = s_q; dst = D_K0; end
			6'd19: begin req.op = akf_pkg::OP_DIV; req.a = p01_q; req.b = s_q; dst = D_K1; end
			6'd20: begin req.op = akf_pkg::OP_SUB; req.a = z_q; req.b = xp_q; dst = D_Y; end
			6'd21: begin req.a = y_q;   req.b = y_q;   dst = D_TMP; end
			6'd22: begin req.op = akf_pkg::OP_DIV; req.a = tmp_q; req.b = s_q; dst = D_RES; end
			6'd23: begin req.a = k0_q;  req.b = y_q;   dst = D_TMP; end
			6'd24: begin req.op = akf_pkg::OP_ADD; req.a = xp_q; req.b = tmp_q; dst = D_POS; end
			6'd25: begin req.a = k1_q;  req.b = y_q;   dst = D_TMP; end
			6'd26: begin req.op = akf_pkg::OP_ADD; req.a = vel_q; req.b = tmp_q; dst = D_VEL; end
			6'd27: begin req.a = k0_q;  req.b = p00_q; dst = D_TMP; end
			6'd28: begin req.op = akf_pkg::OP_SUB; req.a = p00_q; req.b = tmp_q; dst = D_C00; end
			6'd29: begin req.a = k0_q;  req.b = p01_q; dst = D_TMP; end
			6'd30: begin req.op = akf_pkg::OP_SUB; req.a = p01_q; req.b = tmp_q; dst = D_C01; end
			6'd31: begin req.a = k1_q;  req.b = p01_q; dst = D_TMP; end
			6'd32: begin req.op = akf_pkg::OP_SUB; req.a = p11_q; req.b = tmp_q; dst = D_C11; end
			default: ;
		endcase
	end

	akf_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	logic [63:0] wb_w;
	assign wb_w = rsp.y >> shr;

	// result formatting
	logic [63:0] res_c_w, pm_w, pr_w;
	logic [31:0] pos_out_w;
	logic        pneg_w, high_w;
	assign res_c_w = res_q[63] ? 64'd0 : res_q;
	assign high_w  = res_c_w > {1'b0, res_thr_q};
	assign pneg_w  = pos_q[63];
	assign pm_w    = akf_pkg::mag64(pos_q) + (64'd1 << (akf_pkg::FRAC - 17));
	assign pr_w    = pm_w >> (akf_pkg::FRAC - 16);
	always_comb begin
		if (pneg_w) begin
			pos_out_w = (pr_w > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - pr_w[31:0]);
		end else begin
			pos_out_w = (pr_w > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : pr_w[31:0];
		end
	end

	logic out_free;
	assign out_free = !out_vld_q || results.ready;

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			issued_q  <= 1'b0;
			noise_q   <= NL_INIT;
			out_vld_q <= 1'b0;
		end else begin
			// output slot: filled at writeback, freed by a result transfer
			if (state_q == S_WB && out_free) begin
				out_vld_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						step_q   <= '0;
						issued_q <= 1'b0;
						state_q  <= S_RUN;
						if (samples.start_of_series) begin
							noise_q <= NL_INIT;
						end
					end
				end
				S_RUN: begin
					if (rsp.done) begin
						issued_q <= 1'b0;
						if (step_q == LAST_STEP) begin
							state_q <= S_WB;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end else if (req.start) begin
						issued_q <= 1'b1;
					end
				end
				S_WB: begin
					if (out_free) begin
						noise_q   <= high_w ? NL_HIGH : NL_LOW;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// filter state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			c00_q <= '0;
			c01_q <= '0;
			c11_q <= '0;
		end else if (in_xfer && samples.start_of_series) begin
			pos_q <= z_w;
			vel_q <= '0;
			c00_q <= {1'b0, init_cov_q};
			c01_q <= '0;
			c11_q <= {1'b0, init_cov_q};
		end else if (state_q == S_RUN && rsp.done) begin
			unique case (dst)
				D_POS: pos_q <= wb_w;
				D_VEL: vel_q <= wb_w;
				D_C00: c00_q <= wb_w;
				D_C01: c01_q <= wb_w;
				D_C11: c11_q <= wb_w;
				default: ;
			endcase
		end
	end

	// working registers and sample capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			z_q <= z_w;
			if (samples.start_of_series || noise_q == NL_INIT) begin
				qv_q <= {1'b0, init_pvar_q};
			end else if (noise_q == NL_LOW) begin
				qv_q <= {1'b0, low_pvar_q};
			end else begin
				qv_q <= {1'b0, high_pvar_q};
			end
		end
		if (state_q == S_RUN && rsp.done) begin
			unique case (dst)
				D_DT2: dt2_q <= wb_w;
				D_DT3: dt3_q <= wb_w;
				D_DT4: dt4_q <= wb_w;
				D_Q00: q00_q <= wb_w;
				D_Q01: q01_q <= wb_w;
				D_Q11: q11_q <= wb_w;
				D_TMP: tmp_q <= wb_w;
				D_XP:  xp_q  <= wb_w;
				D_A:   a_q   <= wb_w;
				D_B:   b_q   <= wb_w;
				D_P00: p00_q <= wb_w;
				D_P01: p01_q <= wb_w;
				D_P11: p11_q <= wb_w;
				D_S:   s_q   <= wb_w;
				D_K0:  k0_q  <= wb_w;
				D_K1:  k1_q  <= wb_w;
				D_Y:   y_q   <= wb_w;
				D_RES: res_q <= wb_w;
				default: ;
			endcase
		end
		if (state_q == S_WB && out_free) begin
			out_pos_q <= pos_out_w;
			out_res_q <= res_c_w[62:0];
		end
	end

	assign results.valid               = out_vld_q;
	assign results.filtered_position   = out_pos_q;
	assign results.normalized_residual = out_res_q;

endmodule

### rtl/akf_alu.sv
module akf_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  akf_pkg::alu_req_t req,
	output akf_pkg::alu_rsp_t rsp
);

	typedef enum logic [3:0] {
		AS_IDLE = 4'b0001,
		AS_MUL  = 4'b0010,
		AS_DIV  = 4'b0100,
		AS_FIN  = 4'b1000
	} alu_state_t;

	alu_state_t ast_q;
	logic [63:0] ma_q, mb_q;
	logic        neg_q;
	logic        isdiv_q;
	logic [akf_pkg::CNT_W-1:0] cnt_q;
	logic [127:0] acc_q;
	logic [akf_pkg::DIV_BITS-1:0] num_q;
	logic [63:0] rem_q;
	logic        done_q;
	logic [63:0] y_q;

	// saturating add and subtract
	logic [64:0] sum_w, dif_w;
	logic [63:0] add_r, sub_r;
	assign sum_w = {req.a[63], req.a} + {req.b[63], req.b};
	assign dif_w = {req.a[63], req.a} - {req.b[63], req.b};
	assign add_r = (sum_w[64] != sum_w[63]) ? (sum_w[64] ? akf_pkg::MIN64 : akf_pkg::MAX64)
		: sum_w[63:0];
	assign sub_r = (dif_w[64] != dif_w[63]) ? (dif_w[64] ? akf_pkg::MIN64 : akf_pkg::MAX64)
		: dif_w[63:0];

	// operand magnitudes at issue
	logic [63:0] ma_w, mb_w;
	assign ma_w = akf_pkg::mag64(req.a);
	assign mb_w = akf_pkg::mag64(req.b);

	// one 32x32 partial product per cycle
	logic [31:0]  ah_w, bh_w;
	logic [63:0]  pp_w;
	logic [127:0] pps_w;
	assign ah_w = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign bh_w = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp_w = 64'(ah_w) * 64'(bh_w);
	always_comb begin
		unique case (cnt_q[1:0])
			2'b00:   pps_w = {64'd0, pp_w};
			2'b11:   pps_w = {pp_w, 64'd0};
			default: pps_w = {32'd0, pp_w, 32'd0};
		endcase
	end

	// one restoring division step per cycle
	logic [64:0] rsh_w;
	logic        ge_w;
	assign rsh_w = {rem_q, num_q[akf_pkg::DIV_BITS-1]};
	assign ge_w  = rsh_w >= {1'b0, mb_q};

	// rounding and saturation of the finished result
	logic [127:0] rnd_w;
	logic [63:0]  fin_w;
	assign rnd_w = acc_q + (128'd1 << (akf_pkg::FRAC - 1));
	always_comb begin
		if (isdiv_q) begin
			if (num_q[akf_pkg::DIV_BITS-1:64] != '0) begin
				fin_w = neg_q ? akf_pkg::MIN64 : akf_pkg::MAX64;
			end else begin
				fin_w = akf_pkg::sat_from(num_q[63:0], neg_q);
			end
		end else begin
			if (rnd_w[127:64+akf_pkg::FRAC] != '0) begin
				fin_w = neg_q ? akf_pkg::MIN64 : akf_pkg::MAX64;
			end else begin
				fin_w = akf_pkg::sat_from(rnd_w[63+akf_pkg::FRAC:akf_pkg::FRAC], neg_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ast_q  <= AS_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (ast_q)
				AS_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							akf_pkg::OP_ADD: begin
								y_q    <= add_r;
								done_q <= 1'b1;
							end
							akf_pkg::OP_SUB: begin
								y_q    <= sub_r;
								done_q <= 1'b1;
							end
							akf_pkg::OP_MUL: begin
								ma_q    <= ma_w;
								mb_q    <= mb_w;
								neg_q   <= req.a[63] ^ req.b[63];
								isdiv_q <= 1'b0;
								acc_q   <= '0;
								cnt_q   <= '0;
								ast_q   <= AS_MUL;
							end
							akf_pkg::OP_DIV: begin
								if (req.b == '0) begin
									y_q    <= '0;
									done_q <= 1'b1;
								end else begin
									mb_q    <= mb_w;
									neg_q   <= req.a[63] ^ req.b[63];
									isdiv_q <= 1'b1;
									num_q   <= {ma_w, akf_pkg::FRAC'(0)}
										+ akf_pkg::DIV_BITS'(mb_w >> 1);
									rem_q   <= '0;
									cnt_q   <= '0;
									ast_q   <= AS_DIV;
								end
							end
						endcase
					end
				end
				AS_MUL: begin
					acc_q <= acc_q + pps_w;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'b11) begin
						ast_q <= AS_FIN;
					end
				end
				AS_DIV: begin
					rem_q <= ge_w ? 64'(rsh_w - {1'b0, mb_q}) : rsh_w[63:0];
					num_q <= {num_q[akf_pkg::DIV_BITS-2:0], ge_w};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == akf_pkg::CNT_W'(akf_pkg::DIV_BITS - 1)) begin
						ast_q <= AS_FIN;
					end
				end
				AS_FIN: begin
					y_q    <= fin_w;
					done_q <= 1'b1;
					ast_q  <= AS_IDLE;
				end
				default: ast_q <= AS_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.y    = y_q;

endmodule

### rtl/akf_checker.sv
module akf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_pos,
	input logic [62:0] out_res
);

	// a sample transfer is followed by busy cycles
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("filter ready right after a sample transfer");

	// a result cannot appear in the cycle right after a sample transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared without computation time");

	// a stalled result holds its value
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_res))
		else $error("stalled result changed");

	// nothing pending once reset has been seen
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind adaptive_kalman_2state_core akf_checker u_akf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_pos  (results.filtered_position),
	.out_res  (results.normalized_residual)
);
